[rtl/tftp_rts_pkg.sv]
`default_nettype none

package tftp_rts_pkg;

    // payload bytes per data block
    localparam int unsigned BLOCK_BYTES = 512;
    localparam logic [31:0] BLOCK_BYTES_W = 32'(BLOCK_BYTES);
    localparam int unsigned DLEN_W = 10;

    // event kinds
    localparam logic [1:0] CMD_REQUEST = 2'd0;
    localparam logic [1:0] CMD_XFER    = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    // packet opcodes
    localparam logic [15:0] OP_RRQ = 16'd1;
    localparam logic [15:0] OP_WRQ = 16'd2;
    localparam logic [15:0] OP_ACK = 16'd4;

    // shortest packet that carries a header
    localparam logic [10:0] MIN_PKT_LEN = 11'd4;

    // send actions
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_ERROR = 2'd2;
    localparam logic [1:0] ACT_ABORT = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NOT_FOUND = 2'd1;
    localparam logic [1:0] ERR_NO_WRITE  = 2'd2;

    // register map, index in bits [2] of the byte address
    localparam int unsigned PADDR_W = 3;
    localparam logic REG_FILE_SIZE   = 1'b0;
    localparam logic REG_RETRY_LIMIT = 1'b1;

    localparam logic [31:0] FILE_SIZE_RST   = 32'd0;
    localparam logic [3:0]  RETRY_LIMIT_RST = 4'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] pkt_opcode;
        logic [15:0] pkt_block;
        logic [10:0] pkt_length;
    } evt_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [15:0]       out_block;
        logic [31:0]       data_offset;
        logic [DLEN_W-1:0] data_length;
        logic [1:0]        error_code;
        logic              transfer_done;
    } snd_t;

    typedef struct packed {
        logic [31:0] file_size;
        logic [3:0]  retry_limit;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/tftp_rts_cfg.sv]
`default_nettype none

module tftp_rts_cfg
    import tftp_rts_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output cfg_t                    cfg
);

    logic [31:0] file_size_reg;
    logic [3:0]  retry_limit_reg;
    logic        wr_en;

    assign wr_en = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_size_reg   <= FILE_SIZE_RST;
            retry_limit_reg <= RETRY_LIMIT_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_FILE_SIZE)
            begin
                file_size_reg <= pwdata;
            end
            else
            begin
                retry_limit_reg <= pwdata[3:0];
            end
        end
    end

    // register reads
    always_comb
    begin
        if (paddr[2] == REG_RETRY_LIMIT)
        begin
            prdata = {28'd0, retry_limit_reg};
        end
        else
        begin
            prdata = file_size_reg;
        end
    end

    assign cfg.file_size   = file_size_reg;
    assign cfg.retry_limit = retry_limit_reg;

endmodule

`default_nettype wire

[rtl/tftp_rts_core.sv]
`default_nettype none

module tftp_rts_core
    import tftp_rts_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic fire,
    input  wire evt_t item,
    output snd_t      result,
    output logic      busy
);

    logic        busy_reg, busy_next;
    logic [15:0] block_reg, block_next;
    logic [31:0] bytes_reg, bytes_next;
    logic [3:0]  attempts_reg, attempts_next;

    logic              len_ok;
    logic              remaining;
    logic [31:0]       left;
    logic [31:0]       left_after;
    logic              last_block;
    logic [31:0]       bytes_after_ack;
    logic [15:0]       block_inc;
    logic [DLEN_W-1:0] cur_len;
    logic [DLEN_W-1:0] next_len;
    logic [DLEN_W-1:0] first_len;
    logic              ack_match;
    logic              whole_blocks;

    // block geometry from the current position
    assign len_ok     = item.pkt_length >= MIN_PKT_LEN;
    assign remaining  = cfg.file_size > bytes_reg;
    assign left       = cfg.file_size - bytes_reg;
    assign left_after = left - BLOCK_BYTES_W;
    assign last_block = !remaining || (left <= BLOCK_BYTES_W);
    assign block_inc  = block_reg + 16'd1;

    assign cur_len   = !remaining ? '0 :
                       (left < BLOCK_BYTES_W) ? left[DLEN_W-1:0] : BLOCK_BYTES_W[DLEN_W-1:0];
    assign next_len  = (left_after < BLOCK_BYTES_W) ? left_after[DLEN_W-1:0]
                                                     : BLOCK_BYTES_W[DLEN_W-1:0];
    assign first_len = (cfg.file_size < BLOCK_BYTES_W) ? cfg.file_size[DLEN_W-1:0]
                                                        : BLOCK_BYTES_W[DLEN_W-1:0];

    always_comb
    begin
        if (!remaining)
        begin
            bytes_after_ack = bytes_reg;
        end
        else if (left <= BLOCK_BYTES_W)
        begin
            bytes_after_ack = cfg.file_size;
        end
        else
        begin
            bytes_after_ack = bytes_reg + BLOCK_BYTES_W;
        end
    end

    assign ack_match = (item.cmd == CMD_XFER) && len_ok && (item.pkt_opcode == OP_ACK)
                       && (item.pkt_block == block_reg);
    assign whole_blocks = (cfg.file_size % BLOCK_BYTES) == 0;

    // next state and result for one event
    always_comb
    begin
        busy_next     = busy_reg;
        block_next    = block_reg;
        bytes_next    = bytes_reg;
        attempts_next = attempts_reg;
        result        = '0;
        if (!busy_reg)
        begin
            if ((item.cmd == CMD_REQUEST) && len_ok)
            begin
                if (item.pkt_opcode == OP_RRQ)
                begin
                    if (cfg.file_size == '0)
                    begin
                        result.action     = ACT_ERROR;
                        result.error_code = ERR_NOT_FOUND;
                    end
                    else
                    begin
                        busy_next          = 1'b1;
                        block_next         = 16'd1;
                        bytes_next         = '0;
                        attempts_next      = 4'd1;
                        result.action      = ACT_DATA;
                        result.out_block   = 16'd1;
                        result.data_offset = '0;
                        result.data_length = first_len;
                    end
                end
                else if (item.pkt_opcode == OP_WRQ)
                begin
                    result.action     = ACT_ERROR;
                    result.error_code = ERR_NO_WRITE;
                end
            end
        end
        else if (ack_match)
        begin
            block_next = block_inc;
            bytes_next = bytes_after_ack;
            if (last_block)
            begin
                busy_next            = 1'b0;
                attempts_next        = '0;
                result.transfer_done = 1'b1;
                if (whole_blocks)
                begin
                    result.action      = ACT_DATA;
                    result.out_block   = block_inc;
                    result.data_offset = bytes_after_ack;
                end
            end
            else
            begin
                attempts_next      = 4'd1;
                result.action      = ACT_DATA;
                result.out_block   = block_inc;
                result.data_offset = bytes_after_ack;
                result.data_length = next_len;
            end
        end
        else if ((item.cmd == CMD_XFER) || (item.cmd == CMD_TIMEOUT))
        begin
            if (attempts_reg >= cfg.retry_limit)
            begin
                busy_next        = 1'b0;
                result.action    = ACT_ABORT;
                result.out_block = block_reg;
            end
            else
            begin
                attempts_next      = attempts_reg + 4'd1;
                result.action      = ACT_DATA;
                result.out_block   = block_reg;
                result.data_offset = bytes_reg;
                result.data_length = cur_len;
            end
        end
    end

    // transfer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            block_reg    <= 16'd1;
            bytes_reg    <= '0;
            attempts_reg <= '0;
        end
        else if (fire)
        begin
            busy_reg     <= busy_next;
            block_reg    <= block_next;
            bytes_reg    <= bytes_next;
            attempts_reg <= attempts_next;
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

[rtl/tftp_read_transfer_sender_unit.sv]
`default_nettype none

// TFTP read transfer sender, server side, stop-and-wait.
// evt channel: one item per received packet header or receive timeout
// (cmd, opcode, block number, length). snd channel: one item per event,
// telling the packet engine to send a data block, send an error, report
// an abort, or do nothing; transfer_done marks the completing event.
// Both channels use valid/ready; an item moves when both are high.
// Path: an event item is captured in the input register, the core computes
// its result, and the result is captured in the output register.
// Throughput: one item per cycle while the receiver does not stall, with
// the core's state update between the two registers.
// When the receiver stalls, the result holds in the output register and
// one more event waits in the input register; then evt_ready drops.
// Configuration goes through the APB port: file_size at 0x0, retry_limit
// at 0x4; write only while no item is in flight.
// Reset clears both registers' valid bits and puts the transfer state idle
// with block 1; file_size resets to 0 and retry_limit to 5.
module tftp_read_transfer_sender_unit
    import tftp_rts_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               evt_valid,
    output logic                    evt_ready,
    input  wire evt_t               evt,
    output logic                    snd_valid,
    input  wire logic               snd_ready,
    output snd_t                    snd
);

    cfg_t cfg;
    logic evt_valid_reg;
    evt_t evt_reg;
    logic snd_valid_reg;
    snd_t snd_reg;
    snd_t result;
    logic busy;
    logic advance;
    logic fire;

    assign pready = 1'b1;

    tftp_rts_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // pipeline flow control
    assign advance   = !snd_valid_reg || snd_ready;
    assign evt_ready = !evt_valid_reg || advance;
    assign fire      = evt_valid_reg && advance;

    tftp_rts_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (fire),
        .item   (evt_reg),
        .result (result),
        .busy   (busy)
    );

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
        end
        else if (evt_ready)
        begin
            evt_valid_reg <= evt_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (evt_valid && evt_ready)
        begin
            evt_reg <= evt;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snd_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            snd_valid_reg <= evt_valid_reg;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            snd_reg <= result;
        end
    end

    assign snd_valid = snd_valid_reg;
    assign snd       = snd_reg;

    // an abort leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (result.action == ACT_ABORT)) |=> !busy)
        else $error("transfer still busy after abort");

    // a completed transfer leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.transfer_done) |=> !busy)
        else $error("transfer still busy after completion");

    // data blocks never exceed the block size
    assert property (@(posedge clk) disable iff (!rst_n)
        (snd_valid_reg && (snd_reg.action == ACT_DATA))
            |-> ({22'd0, snd_reg.data_length} <= BLOCK_BYTES_W))
        else $error("data block longer than block size");

    // error items carry a real error code
    assert property (@(posedge clk) disable iff (!rst_n)
        (snd_valid_reg && (snd_reg.action == ACT_ERROR))
            |-> ((snd_reg.error_code == ERR_NOT_FOUND)
                 || (snd_reg.error_code == ERR_NO_WRITE)))
        else $error("error item without error code");

endmodule

`default_nettype wire
